// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_SAME_CYCLE(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT_CYCLE(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== sv/htt_pkg.sv =====
// types, codes and constants of the request header tokenizer
package htt_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT   = 4;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   localparam logic [2:0] TAG_EVENT   = 3'd0;
   localparam logic [2:0] TAG_METHOD  = 3'd1;
   localparam logic [2:0] TAG_URI     = 3'd2;
   localparam logic [2:0] TAG_VERSION = 3'd3;
   localparam logic [2:0] TAG_NAME    = 3'd4;
   localparam logic [2:0] TAG_VALUE   = 3'd5;

   // token phases share their codes with the byte tags
   localparam logic [2:0] PH_METHOD  = TAG_METHOD;
   localparam logic [2:0] PH_URI     = TAG_URI;
   localparam logic [2:0] PH_VERSION = TAG_VERSION;
   localparam logic [2:0] PH_NAME    = TAG_NAME;
   localparam logic [2:0] PH_VALUE   = TAG_VALUE;

   localparam logic [1:0] ST_INCOMPLETE = 2'd0;
   localparam logic [1:0] ST_OK         = 2'd1;
   localparam logic [1:0] ST_FAIL       = 2'd2;

   localparam logic [1:0] METH_UNKNOWN = 2'd0;
   localparam logic [1:0] METH_GET     = 2'd1;
   localparam logic [1:0] METH_HEAD    = 2'd2;
   localparam logic [1:0] METH_POST    = 2'd3;

   localparam logic [2:0] VERSION_SKIP = 3'd5;
   localparam logic [2:0] VALUE_SKIP   = 3'd1;
   localparam logic [2:0] MLEN_MAX     = 3'd7;

   // method spellings: GET, HEAD, POST
   localparam logic [7:0] METH_TEXT [3][4] = '{
      '{8'h47, 8'h45, 8'h54, 8'h00},
      '{8'h48, 8'h45, 8'h41, 8'h44},
      '{8'h50, 8'h4F, 8'h53, 8'h54}
   };
   localparam logic [2:0] METH_LEN [3] = '{3'd3, 3'd4, 3'd4};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_request;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] byte_tag;
      logic       field_end;
      logic [1:0] request_status;
      logic [1:0] method_code;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_request;
      logic       is_cr;
      logic       is_lf;
      logic       is_space;
      logic       is_colon;
   } cls_item_type;

   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } rsp_wr_type;

   typedef struct packed {
      logic       cr_pending;
      logic       past_first_line;
      logic       line_nonempty;
      logic [2:0] token_phase;
      logic [2:0] skip_count;
      logic [2:0] method_candidates;
      logic [2:0] method_length;
      logic       method_invalid;
      logic [1:0] status_reg;
      logic [1:0] method_reg;
   } state_type;

   localparam state_type RESET_STATE = '{
      cr_pending:        1'b0,
      past_first_line:   1'b0,
      line_nonempty:     1'b0,
      token_phase:       PH_METHOD,
      skip_count:        3'd0,
      method_candidates: 3'b111,
      method_length:     3'd0,
      method_invalid:    1'b0,
      status_reg:        ST_INCOMPLETE,
      method_reg:        METH_UNKNOWN
   };

endpackage

// ===== sv/http_request_header_tokenizer.sv =====
// HTTP request header tokenizer: one request byte in, zero to two tagged results out.
// Throughput is one byte per clock while each byte gives at most one result and the
// results are popped as they come; a byte that releases a held CR together with itself
// gives two results, which leave the single result port one after the other. An accepted
// byte first waits in the classified-item queue; its results are then written into the
// result queue, from which they show on the result ports and can be popped. Both queue
// depths are parameters: QUEUE_DEPTH a power of two of at least 2, RSP_DEPTH a power
// of two of at least 4. No clearing pass is needed after reset.
module http_request_header_tokenizer #(
   parameter int QUEUE_DEPTH = htt_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int RSP_DEPTH   = htt_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  htt_pkg::req_type req_item,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output htt_pkg::rsp_type rsp_item
);
   localparam int CLS_W = $bits(htt_pkg::cls_item_type);

   logic                  q_full, q_push, q_pop, q_empty, buf_room;
   htt_pkg::cls_item_type q_wr_item;
   logic [CLS_W-1:0]      q_rd_data;
   htt_pkg::rsp_wr_type   buf_wr;

   htt_front u_front (
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_item)
   );

   htt_queue #(
      .WIDTH (CLS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_item),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   htt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_item   (htt_pkg::cls_item_type'(q_rd_data)),
      .q_pop    (q_pop),
      .buf_room (buf_room),
      .buf_wr   (buf_wr)
   );

   htt_rsp_buffer #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_buffer (
      .clock (clock),
      .reset (reset),
      .wr    (buf_wr),
      .room  (buf_room),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .head  (rsp_item)
   );
endmodule

// ===== sv/htt_queue.sv =====
// small first-in first-out queue of classified items
module htt_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = htt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = store_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

// ===== sv/htt_front.sv =====
// front end: accepts request bytes and classifies delimiters
module htt_front (
   input  logic                  req_push,
   input  htt_pkg::req_type      req_item,
   output logic                  req_full,
   input  logic                  q_full,
   output logic                  q_push,
   output htt_pkg::cls_item_type q_data
);
   assign req_full = q_full;
   assign q_push   = req_push & ~q_full;

   always_comb begin
      q_data.data_byte   = req_item.data_byte;
      q_data.new_request = req_item.new_request;
      q_data.is_cr       = (req_item.data_byte == htt_pkg::CHAR_CR);
      q_data.is_lf       = (req_item.data_byte == htt_pkg::CHAR_LF);
      q_data.is_space    = (req_item.data_byte == htt_pkg::CHAR_SPACE);
      q_data.is_colon    = (req_item.data_byte == htt_pkg::CHAR_COLON);
   end
endmodule

// ===== sv/htt_back.sv =====
// back end: token state machine, up to two results per item
module htt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  htt_pkg::cls_item_type q_item,
   output logic                  q_pop,
   input  logic                  buf_room,
   output htt_pkg::rsp_wr_type   buf_wr
);
   typedef struct packed {
      htt_pkg::state_type st;
      logic               valid;
      htt_pkg::rsp_type   rsp;
   } step_type;

   function automatic htt_pkg::rsp_type make_rsp(logic [7:0] b, logic [2:0] tag,
                                                  logic fend, htt_pkg::state_type s);
      htt_pkg::rsp_type r;
      r.out_byte       = b;
      r.byte_tag       = tag;
      r.field_end      = fend;
      r.request_status = s.status_reg;
      r.method_code    = s.method_reg;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   function automatic step_type content(htt_pkg::state_type s, logic [7:0] c,
                                        logic is_sp, logic is_colon);
      step_type o;
      int       k;
      o.st               = s;
      o.valid            = 1'b0;
      o.rsp              = '0;
      o.st.line_nonempty = 1'b1;
      unique case (s.token_phase)
         htt_pkg::PH_METHOD: begin
            if (is_sp) begin
               if (!s.method_invalid && s.method_candidates[0] && s.method_length == 3'd3) begin
                  o.st.method_reg = htt_pkg::METH_GET;
               end else if (!s.method_invalid && s.method_candidates[1] &&
                            s.method_length == 3'd4) begin
                  o.st.method_reg = htt_pkg::METH_HEAD;
               end else if (!s.method_invalid && s.method_candidates[2] &&
                            s.method_length == 3'd4) begin
                  o.st.method_reg = htt_pkg::METH_POST;
               end else begin
                  o.st.status_reg = htt_pkg::ST_FAIL;
               end
               o.st.token_phase = htt_pkg::PH_URI;
               o.valid = 1'b1;
               o.rsp   = make_rsp(8'd0, htt_pkg::TAG_EVENT, 1'b1, o.st);
            end else begin
               for (k = 0; k < 3; k++) begin
                  if (!(s.method_length < htt_pkg::METH_LEN[k] &&
                        htt_pkg::METH_TEXT[k][s.method_length[1:0]] == c)) begin
                     o.st.method_candidates[k] = 1'b0;
                  end
               end
               if (o.st.method_candidates == 3'd0) begin
                  o.st.method_invalid = 1'b1;
               end
               if (s.method_length < htt_pkg::MLEN_MAX) begin
                  o.st.method_length = s.method_length + 3'd1;
               end
               o.valid = 1'b1;
               o.rsp   = make_rsp(c, htt_pkg::TAG_METHOD, 1'b0, o.st);
            end
         end
         htt_pkg::PH_URI: begin
            o.valid = 1'b1;
            if (is_sp) begin
               o.st.token_phase = htt_pkg::PH_VERSION;
               o.st.skip_count  = htt_pkg::VERSION_SKIP;
               o.rsp = make_rsp(8'd0, htt_pkg::TAG_EVENT, 1'b1, o.st);
            end else begin
               o.rsp = make_rsp(c, htt_pkg::TAG_URI, 1'b0, o.st);
            end
         end
         htt_pkg::PH_VERSION, htt_pkg::PH_VALUE: begin
            if (s.skip_count != 3'd0) begin
               o.st.skip_count = s.skip_count - 3'd1;
            end else begin
               o.valid = 1'b1;
               o.rsp   = make_rsp(c, s.token_phase, 1'b0, o.st);
            end
         end
         htt_pkg::PH_NAME: begin
            o.valid = 1'b1;
            if (is_colon) begin
               o.st.token_phase = htt_pkg::PH_VALUE;
               o.st.skip_count  = htt_pkg::VALUE_SKIP;
               o.rsp = make_rsp(8'd0, htt_pkg::TAG_EVENT, 1'b1, o.st);
            end else begin
               o.rsp = make_rsp(c, htt_pkg::TAG_NAME, 1'b0, o.st);
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic step_type line_end(htt_pkg::state_type s);
      step_type o;
      o.st = s;
      if (!s.line_nonempty) begin
         o.st.status_reg = s.past_first_line ? htt_pkg::ST_OK : htt_pkg::ST_FAIL;
      end else if (!s.past_first_line && s.token_phase == htt_pkg::PH_METHOD) begin
         o.st.status_reg = htt_pkg::ST_FAIL;
      end
      o.st.past_first_line = 1'b1;
      o.st.line_nonempty   = 1'b0;
      o.st.token_phase     = htt_pkg::PH_NAME;
      o.st.skip_count      = 3'd0;
      o.valid = 1'b1;
      o.rsp   = make_rsp(8'd0, htt_pkg::TAG_EVENT, 1'b1, o.st);
      return o;
   endfunction

   htt_pkg::state_type st_ff, st_in, s;
   step_type           a, b;
   logic               fire;
   logic [1:0]         num;

   assign fire  = ~q_empty & buf_room;
   assign q_pop = fire;

   always_comb begin
      s = st_ff;
      a = '0;
      b = '0;
      if (q_item.new_request) begin
         s = htt_pkg::RESET_STATE;
      end
      if (s.status_reg == htt_pkg::ST_INCOMPLETE) begin
         priority if (!s.cr_pending) begin
            if (q_item.is_cr) begin
               s.cr_pending = 1'b1;
            end else begin
               a = content(s, q_item.data_byte, q_item.is_space, q_item.is_colon);
               s = a.st;
            end
         end else if (q_item.is_lf) begin
            s.cr_pending = 1'b0;
            a = line_end(s);
            s = a.st;
         end else if (q_item.is_cr) begin
            a = content(s, htt_pkg::CHAR_CR, 1'b0, 1'b0);
            s = a.st;
         end else begin
            s.cr_pending = 1'b0;
            a = content(s, htt_pkg::CHAR_CR, 1'b0, 1'b0);
            s = a.st;
            if (s.status_reg == htt_pkg::ST_INCOMPLETE) begin
               b = content(s, q_item.data_byte, q_item.is_space, q_item.is_colon);
               s = b.st;
            end
         end
      end
      st_in = fire ? s : st_ff;
   end

   always_comb begin
      num = {1'b0, a.valid} + {1'b0, b.valid};
      buf_wr.num                = fire ? num : 2'd0;
      buf_wr.first              = a.valid ? a.rsp : b.rsp;
      buf_wr.first.last_of_run  = ~(a.valid & b.valid);
      buf_wr.second             = b.rsp;
      buf_wr.second.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= htt_pkg::RESET_STATE;
      end else begin
         st_ff <= st_in;
      end
   end
endmodule

// ===== sv/htt_rsp_buffer.sv =====
// result queue, takes up to two results a cycle and gives one
module htt_rsp_buffer #(
   parameter int DEPTH = htt_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  htt_pkg::rsp_wr_type wr,
   output logic                room,
   input  logic                pop,
   output logic                empty,
   output htt_pkg::rsp_type    head
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   htt_pkg::rsp_type store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   assign empty  = (count_ff == '0);
   assign room   = (count_ff <= CW'(DEPTH - 2));
   assign head   = store_ff[rd_ptr_ff];
   assign do_pop = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(wr.num);
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(wr.num) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (wr.num != 2'd0) begin
         store_ff[wr_ptr_ff] <= wr.first;
      end
      if (wr.num == 2'd2) begin
         store_ff[wr_ptr_ff + PW'(1)] <= wr.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

// ===== sv/htt_checker.sv =====
// port-level checks of the tokenizer, bound to the top level
`include "assert_macros.svh"

module htt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input htt_pkg::req_type req_item,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input htt_pkg::rsp_type rsp_item
);
   `ASSERT_NEXT_CYCLE(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full)
   `ASSERT_NEXT_CYCLE(a_stalled_result_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_item))
   `ASSERT_SAME_CYCLE(a_event_is_zero_byte, clock, reset, !rsp_empty && rsp_item.byte_tag == htt_pkg::TAG_EVENT, rsp_item.out_byte == 8'd0)
   `ASSERT_SAME_CYCLE(a_field_end_on_events, clock, reset, !rsp_empty, (rsp_item.field_end == (rsp_item.byte_tag == htt_pkg::TAG_EVENT)) && rsp_item.byte_tag <= htt_pkg::TAG_VALUE)
endmodule

bind http_request_header_tokenizer htt_checker u_checker (.*);

// ===== test/testbench.sv =====
// testbench for the request header tokenizer: random byte streams checked against a token predictor
`timescale 1ns / 1ps

module testbench;
   import htt_pkg::*;

   localparam int ITEM_TARGET = 700;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 250;

   class token_scoreboard;
      logic       cr_held;
      logic       first_done;
      logic       line_used;
      logic       meth_bad;
      logic [2:0] phase;
      logic [2:0] skip_left;
      logic [2:0] cands;
      logic [2:0] meth_len;
      logic [1:0] status;
      logic [1:0] meth;
      rsp_type    step_tokens[$];
      rsp_type    expected_tokens[$];
      int         errors;
      int         printed;
      int         checked;
      int         ok_count;
      int         fail_count;

      function new();
         clear_request();
         errors = 0;
         printed = 0;
         checked = 0;
         ok_count = 0;
         fail_count = 0;
      endfunction

      function void clear_request();
         cr_held = 1'b0;
         first_done = 1'b0;
         line_used = 1'b0;
         meth_bad = 1'b0;
         phase = PH_METHOD;
         skip_left = 3'd0;
         cands = 3'b111;
         meth_len = 3'd0;
         status = ST_INCOMPLETE;
         meth = METH_UNKNOWN;
      endfunction

      function logic [7:0] spelling(int k, int i);
         string s;
         case (k)
            0: s = "GET";
            1: s = "HEAD";
            default: s = "POST";
         endcase
         if (i < s.len()) return s[i];
         return 8'h00;
      endfunction

      function void emit(logic [7:0] b, logic [2:0] tag, logic fe);
         rsp_type r;
         r.out_byte = b;
         r.byte_tag = tag;
         r.field_end = fe;
         r.request_status = status;
         r.method_code = meth;
         r.last_of_run = 1'b0;
         step_tokens.push_back(r);
      endfunction

      function void take_content(logic [7:0] c);
         int k;
         int want_len;
         line_used = 1'b1;
         case (phase)
            PH_METHOD: begin
               if (c == CHAR_SPACE) begin
                  if (!meth_bad && cands[0] && meth_len == 3'd3) meth = METH_GET;
                  else if (!meth_bad && cands[1] && meth_len == 3'd4) meth = METH_HEAD;
                  else if (!meth_bad && cands[2] && meth_len == 3'd4) meth = METH_POST;
                  else status = ST_FAIL;
                  phase = PH_URI;
                  emit(8'h00, TAG_EVENT, 1'b1);
               end else begin
                  for (k = 0; k < 3; k++) begin
                     want_len = (k == 0) ? 3 : 4;
                     if (!(meth_len < want_len && spelling(k, meth_len) == c))
                        cands[k] = 1'b0;
                  end
                  if (cands == 3'b000) meth_bad = 1'b1;
                  if (meth_len != MLEN_MAX) meth_len = meth_len + 3'd1;
                  emit(c, TAG_METHOD, 1'b0);
               end
            end
            PH_URI: begin
               if (c == CHAR_SPACE) begin
                  phase = PH_VERSION;
                  skip_left = VERSION_SKIP;
                  emit(8'h00, TAG_EVENT, 1'b1);
               end else begin
                  emit(c, TAG_URI, 1'b0);
               end
            end
            PH_VERSION, PH_VALUE: begin
               if (skip_left != 3'd0) skip_left = skip_left - 3'd1;
               else emit(c, phase, 1'b0);
            end
            PH_NAME: begin
               if (c == CHAR_COLON) begin
                  phase = PH_VALUE;
                  skip_left = VALUE_SKIP;
                  emit(8'h00, TAG_EVENT, 1'b1);
               end else begin
                  emit(c, TAG_NAME, 1'b0);
               end
            end
            default: ;
         endcase
      endfunction

      function void line_finish();
         if (!line_used) status = first_done ? ST_OK : ST_FAIL;
         else if (!first_done && phase == PH_METHOD) status = ST_FAIL;
         first_done = 1'b1;
         line_used = 1'b0;
         phase = PH_NAME;
         skip_left = 3'd0;
         emit(8'h00, TAG_EVENT, 1'b1);
      endfunction

      // returns 1 when the byte was processed, 0 when a finished request ignores it
      function bit note_request_byte(req_type it);
         logic [7:0] c;
         int n;
         c = it.data_byte;
         step_tokens.delete();
         if (it.new_request) clear_request();
         if (status != ST_INCOMPLETE) return 1'b0;
         if (!cr_held) begin
            if (c == CHAR_CR) cr_held = 1'b1;
            else take_content(c);
         end else if (c == CHAR_LF) begin
            cr_held = 1'b0;
            line_finish();
         end else if (c == CHAR_CR) begin
            take_content(CHAR_CR);
         end else begin
            cr_held = 1'b0;
            take_content(CHAR_CR);
            if (status == ST_INCOMPLETE) take_content(c);
         end
         n = step_tokens.size();
         for (int i = 0; i < n; i++) begin
            if (i == n - 1) step_tokens[i].last_of_run = 1'b1;
            expected_tokens.push_back(step_tokens[i]);
         end
         if (status == ST_OK) ok_count++;
         if (status == ST_FAIL) fail_count++;
         return 1'b1;
      endfunction

      task report(string msg);
         errors++;
         if (printed < 30) begin
            $display("ERROR at %0t: %s", $time, msg);
            printed++;
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (expected_tokens.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected (%h)", checked, got));
            return;
         end
         want = expected_tokens.pop_front();
         if (got.out_byte !== want.out_byte)
            report($sformatf("result %0d out_byte %h, want %h",
                             checked, got.out_byte, want.out_byte));
         if (got.byte_tag !== want.byte_tag)
            report($sformatf("result %0d byte_tag %0d, want %0d",
                             checked, got.byte_tag, want.byte_tag));
         if (got.field_end !== want.field_end)
            report($sformatf("result %0d field_end %b, want %b",
                             checked, got.field_end, want.field_end));
         if (got.request_status !== want.request_status)
            report($sformatf("result %0d request_status %0d, want %0d",
                             checked, got.request_status, want.request_status));
         if (got.method_code !== want.method_code)
            report($sformatf("result %0d method_code %0d, want %0d",
                             checked, got.method_code, want.method_code));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("result %0d last_of_run %b, want %b",
                             checked, got.last_of_run, want.last_of_run));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_item = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_item;

   token_scoreboard sb;
   logic [7:0]      stream_bytes[$];
   bit              quiet = 1'b0;
   bit              long_hold_req = 1'b0;
   int              tx_pct = 10;
   int              sent = 0;
   int              handled = 0;
   int              requests = 0;
   int              cycle_count = 0;

   http_request_header_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [7:0] text_char();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'($urandom_range(128, 255));
      if (r == 1) begin
         v = $urandom_range(0, 31);
         if (v == 8'h0D || v == 8'h0A) v = 8'h09;
         return 8'(v);
      end
      v = $urandom_range(33, 126);
      if (v == 8'h3A) v = 8'h7A;
      return 8'(v);
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0: return CHAR_CR;
         1: return CHAR_LF;
         2: return CHAR_SPACE;
         3: return CHAR_COLON;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task add_string(string s);
      for (int i = 0; i < s.len(); i++) stream_bytes.push_back(s[i]);
   endtask

   // content with occasional held CRs and, where allowed, separators
   task add_text(int n, bit allow_sep);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 39);
         if (r < 2) begin
            stream_bytes.push_back(CHAR_CR);
            stream_bytes.push_back(text_char());
         end else if (r == 2) begin
            stream_bytes.push_back(CHAR_CR);
            stream_bytes.push_back(CHAR_CR);
            stream_bytes.push_back(text_char());
         end else if (allow_sep && r < 6) begin
            stream_bytes.push_back(r[0] ? CHAR_SPACE : CHAR_COLON);
         end else begin
            stream_bytes.push_back(text_char());
         end
      end
   endtask

   task add_method();
      string s;
      int    k;
      int    m;
      k = $urandom_range(0, 2);
      s = (k == 0) ? "GET" : (k == 1) ? "HEAD" : "POST";
      m = $urandom_range(0, 9);
      if (m == 7) begin
         case ($urandom_range(0, 2))
            0: s = s.substr(0, s.len() - 2);
            1: s = {s, "T"};
            default: s[$urandom_range(0, s.len() - 1)] = text_char();
         endcase
      end
      if (m >= 8) begin
         add_text($urandom_range(0, 9), 1'b0);
      end else begin
         add_string(s);
      end
   endtask

   task build_request();
      int n;
      stream_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) stream_bytes.push_back(noise_byte());
         return;
      end
      add_method();
      if ($urandom_range(0, 19) == 0) add_string("\r\n");
      stream_bytes.push_back(CHAR_SPACE);
      add_text($urandom_range(0, 6), 1'b0);
      if ($urandom_range(0, 9) != 0) begin
         stream_bytes.push_back(CHAR_SPACE);
         if ($urandom_range(0, 1)) add_string("HTTP/1.1");
         else add_text($urandom_range(0, 8), 1'b1);
      end
      add_string("\r\n");
      n = $urandom_range(0, 3);
      for (int h = 0; h < n; h++) begin
         add_text($urandom_range(1, 6), 1'b0);
         if ($urandom_range(0, 6) != 0) begin
            stream_bytes.push_back(CHAR_COLON);
            if ($urandom_range(0, 4) != 0) stream_bytes.push_back(CHAR_SPACE);
            add_text($urandom_range(0, 8), 1'b1);
         end
         add_string("\r\n");
      end
      if ($urandom_range(0, 9) != 0) add_string("\r\n");
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) stream_bytes.push_back(noise_byte());
      end
   endtask

   task send_item(logic [7:0] b, logic fresh);
      req_type it;
      it.data_byte = b;
      it.new_request = fresh;
      if (!quiet && $urandom_range(1, 100) <= tx_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_item <= it;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      sent++;
      if (sb.note_request_byte(it)) handled++;
   endtask

   task send_stream();
      requests++;
      foreach (stream_bytes[i])
         send_item(stream_bytes[i], i == 0 || $urandom_range(0, 49) == 0);
   endtask

   task drain_sender();
      req_push <= 1'b0;
      do @(posedge clock); while (sb.expected_tokens.size() != 0);
   endtask

   // result side: random stalls plus one long hold on request
   initial begin
      int stall;
      int rx_pct;
      int cyc;
      stall = 0;
      rx_pct = 10;
      cyc = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) sb.check_result(rsp_item);
         cyc++;
         if (cyc % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: rx_pct = 0;
               1: rx_pct = 10;
               2: rx_pct = 30;
               default: rx_pct = 60;
            endcase
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(1, 100) <= rx_pct) begin
            stall = $urandom_range(0, 7);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      bit hold_done;
      bit pause_done;
      hold_done = 1'b0;
      pause_done = 1'b0;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty first line, then a byte after the failure
      stream_bytes.delete();
      add_string("\r\nA");
      send_stream();
      // extreme bytes, held CR released with a zero byte, no space in first line
      stream_bytes.delete();
      stream_bytes.push_back(8'hFF);
      add_string("\r");
      stream_bytes.push_back(8'h00);
      add_string("\r\n");
      send_stream();
      // empty method
      stream_bytes.delete();
      add_string(" ");
      send_stream();
      // early line end, header without colon, completing empty line
      stream_bytes.delete();
      add_string("GET a\r\nb\r\n\r\n");
      send_stream();
      // restart in the middle of a request
      stream_bytes.delete();
      add_string("HEAD ");
      send_stream();
      stream_bytes.delete();
      add_string("POST ");
      send_stream();

      while (sent < ITEM_TARGET) begin
         if (!hold_done && sent >= 200) begin
            long_hold_req = 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && sent >= 400) begin
            drain_sender();
            pause_done = 1'b1;
         end
         if (sent >= ITEM_TARGET - 150) quiet = 1'b1;
         case ($urandom_range(0, 2))
            0: tx_pct = 0;
            1: tx_pct = 10;
            default: tx_pct = 30;
         endcase
         build_request();
         send_stream();
      end

      drain_sender();
      repeat (10) @(posedge clock);
      $display("covered %0d requests (%0d ok, %0d failed), %0d bytes sent, %0d processed",
               requests, sb.ok_count, sb.fail_count, sent, handled);
      $display("checked %0d tokens, %0d errors", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/htt_pkg.sv
sv/htt_queue.sv
sv/htt_front.sv
sv/htt_back.sv
sv/htt_rsp_buffer.sv
sv/http_request_header_tokenizer.sv
sv/htt_checker.sv
test/testbench.sv
